// ----- design/pdstat_pkg.sv -----
package pdstat_pkg;

    // Field and accumulator widths.
    localparam int PIX_W      = 8;
    localparam int CHAN_CNT_W = 3;
    localparam int NUM_CHAN   = 4;
    localparam int SQ_W       = 18;
    localparam int DIFF_CNT_W = 25;
    localparam int SSE_W      = 42;
    localparam int SAMP_W     = 27;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD  = 1'b1;

    // Reset value of the channel count.
    localparam logic [CHAN_CNT_W-1:0] CHANNELS_RESET = 3'd3;

    // One pixel pair.
    typedef struct packed {
        logic [PIX_W-1:0] a_chan0;
        logic [PIX_W-1:0] a_chan1;
        logic [PIX_W-1:0] a_chan2;
        logic [PIX_W-1:0] a_chan3;
        logic [PIX_W-1:0] b_chan0;
        logic [PIX_W-1:0] b_chan1;
        logic [PIX_W-1:0] b_chan2;
        logic [PIX_W-1:0] b_chan3;
        logic             last_pixel;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic [PIX_W-1:0]      diff_red;
        logic [PIX_W-1:0]      diff_green;
        logic [PIX_W-1:0]      diff_blue;
        logic                  frame_done;
        logic [DIFF_CNT_W-1:0] differing_pixels;
        logic [SSE_W-1:0]      squared_error_total;
        logic [SAMP_W-1:0]     sample_total;
    } t_out_item;

    // Per-pixel statistics handed to the accumulators.
    typedef struct packed {
        logic                  differs;
        logic [SQ_W-1:0]       sq_sum;
        logic [CHAN_CNT_W-1:0] samples;
    } t_pix_stats;

    // Running frame totals, including the current pixel.
    typedef struct packed {
        logic [DIFF_CNT_W-1:0] differing_pixels;
        logic [SSE_W-1:0]      squared_error_total;
        logic [SAMP_W-1:0]     sample_total;
    } t_frame_totals;

    // Visual difference pixel.
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_diff_pix;

endpackage

// ----- design/pixel_pair_difference_stats_top.sv -----
// A pixel pair passes through the input register and then the result register before
// the result side can take its result.
// Throughput: one pixel pair per cycle; the single input register and result register
// let a new transaction enter every cycle while the result side takes its results.
// Reset (synchronous, active low) empties both registers, clears the frame totals,
// and sets the channel count to three and the difference threshold to zero.
module pixel_pair_difference_stats_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pdstat_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pdstat_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  pdstat_pkg::t_in_item                 i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output pdstat_pkg::t_out_item                o_out_data
);

    logic [pdstat_pkg::CHAN_CNT_W-1:0] r_chan_eff;
    logic [pdstat_pkg::CHAN_CNT_W-1:0] n_chan_eff;
    logic [pdstat_pkg::PIX_W-1:0]      r_threshold;
    logic                              r_in_valid;
    pdstat_pkg::t_in_item              r_in_item;
    logic                              r_out_valid;
    pdstat_pkg::t_out_item             r_out_item;
    pdstat_pkg::t_out_item             n_out_item;
    logic                              advance;
    pdstat_pkg::t_diff_pix             pix;
    pdstat_pkg::t_pix_stats            stats;
    pdstat_pkg::t_frame_totals         totals;

    // A channel count of zero means one; anything above four means four.
    always_comb begin
        n_chan_eff = i_cfg_data[pdstat_pkg::CHAN_CNT_W-1:0];
        if (n_chan_eff == 3'd0) begin
            n_chan_eff = 3'd1;
        end else if (n_chan_eff > 3'(pdstat_pkg::NUM_CHAN)) begin
            n_chan_eff = 3'(pdstat_pkg::NUM_CHAN);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_eff  <= pdstat_pkg::CHANNELS_RESET;
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pdstat_pkg::CFG_CHANNELS_IN_USE: r_chan_eff <= n_chan_eff;
                pdstat_pkg::CFG_DIFF_THRESHOLD:  r_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: the input register moves on whenever the result register is free.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    pdstat_diff u_diff (
        .i_item      (r_in_item),
        .i_chan_eff  (r_chan_eff),
        .i_threshold (r_threshold),
        .o_pix       (pix),
        .o_stats     (stats)
    );

    pdstat_acc u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_last    (r_in_item.last_pixel),
        .i_stats   (stats),
        .o_totals  (totals)
    );

    // Totals appear only on the frame's last pixel.
    always_comb begin
        n_out_item.diff_red   = pix.red;
        n_out_item.diff_green = pix.green;
        n_out_item.diff_blue  = pix.blue;
        n_out_item.frame_done = r_in_item.last_pixel;
        if (r_in_item.last_pixel) begin
            n_out_item.differing_pixels    = totals.differing_pixels;
            n_out_item.squared_error_total = totals.squared_error_total;
            n_out_item.sample_total        = totals.sample_total;
        end else begin
            n_out_item.differing_pixels    = '0;
            n_out_item.squared_error_total = '0;
            n_out_item.sample_total        = '0;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

// ----- design/pdstat_diff.sv -----
module pdstat_diff (
    input  pdstat_pkg::t_in_item                    i_item,
    input  logic [pdstat_pkg::CHAN_CNT_W-1:0]       i_chan_eff,
    input  logic [pdstat_pkg::PIX_W-1:0]            i_threshold,
    output pdstat_pkg::t_diff_pix                   o_pix,
    output pdstat_pkg::t_pix_stats                  o_stats
);

    logic [pdstat_pkg::PIX_W-1:0]   a_val [pdstat_pkg::NUM_CHAN];
    logic [pdstat_pkg::PIX_W-1:0]   b_val [pdstat_pkg::NUM_CHAN];
    logic [pdstat_pkg::PIX_W-1:0]   d_val [pdstat_pkg::NUM_CHAN];
    logic [2*pdstat_pkg::PIX_W-1:0] sq_val [pdstat_pkg::NUM_CHAN];
    logic [pdstat_pkg::PIX_W-1:0]   amp_val [pdstat_pkg::NUM_CHAN];
    logic [pdstat_pkg::NUM_CHAN-1:0] used;
    logic [pdstat_pkg::NUM_CHAN-1:0] over;
    logic [pdstat_pkg::PIX_W+1:0]   times3 [pdstat_pkg::NUM_CHAN];

    assign a_val[0] = i_item.a_chan0;
    assign a_val[1] = i_item.a_chan1;
    assign a_val[2] = i_item.a_chan2;
    assign a_val[3] = i_item.a_chan3;
    assign b_val[0] = i_item.b_chan0;
    assign b_val[1] = i_item.b_chan1;
    assign b_val[2] = i_item.b_chan2;
    assign b_val[3] = i_item.b_chan3;

    // Per-channel absolute difference, square, threshold test and amplified view.
    always_comb begin
        for (int c = 0; c < pdstat_pkg::NUM_CHAN; c++) begin
            d_val[c]   = (a_val[c] > b_val[c]) ? (a_val[c] - b_val[c]) : (b_val[c] - a_val[c]);
            sq_val[c]  = d_val[c] * d_val[c];
            used[c]    = ({1'b0, i_chan_eff} > (pdstat_pkg::CHAN_CNT_W + 1)'(c));
            over[c]    = used[c] && (d_val[c] > i_threshold);
            times3[c]  = {2'b00, d_val[c]} + {1'b0, d_val[c], 1'b0};
            amp_val[c] = (times3[c] > 10'd255) ? 8'hFF : times3[c][pdstat_pkg::PIX_W-1:0];
        end
    end

    // Sum of squares over the channels in use.
    always_comb begin
        o_stats.sq_sum = '0;
        for (int c = 0; c < pdstat_pkg::NUM_CHAN; c++) begin
            if (used[c]) begin
                o_stats.sq_sum = o_stats.sq_sum + pdstat_pkg::SQ_W'(sq_val[c]);
            end
        end
        o_stats.differs = |over;
        o_stats.samples = i_chan_eff;
    end

    // With fewer than three channels, channel 0 drives all three outputs.
    always_comb begin
        o_pix.red = amp_val[0];
        if (i_chan_eff >= 3'd3) begin
            o_pix.green = amp_val[1];
            o_pix.blue  = amp_val[2];
        end else begin
            o_pix.green = amp_val[0];
            o_pix.blue  = amp_val[0];
        end
    end

endmodule

// ----- design/pdstat_acc.sv -----
module pdstat_acc (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic                       i_last,
    input  pdstat_pkg::t_pix_stats     i_stats,
    output pdstat_pkg::t_frame_totals  o_totals
);

    logic [pdstat_pkg::DIFF_CNT_W-1:0] r_diff_cnt;
    logic [pdstat_pkg::SSE_W-1:0]      r_sse;
    logic [pdstat_pkg::SAMP_W-1:0]     r_samp;
    logic [pdstat_pkg::DIFF_CNT_W:0]   sum_diff;
    logic [pdstat_pkg::SSE_W:0]        sum_sse;
    logic [pdstat_pkg::SAMP_W:0]       sum_samp;

    // Saturating sums that include the current pixel.
    always_comb begin
        sum_diff = {1'b0, r_diff_cnt} + (pdstat_pkg::DIFF_CNT_W + 1)'(i_stats.differs);
        sum_sse  = {1'b0, r_sse} + (pdstat_pkg::SSE_W + 1)'(i_stats.sq_sum);
        sum_samp = {1'b0, r_samp} + (pdstat_pkg::SAMP_W + 1)'(i_stats.samples);
        o_totals.differing_pixels    = sum_diff[pdstat_pkg::DIFF_CNT_W] ? '1
                                     : sum_diff[pdstat_pkg::DIFF_CNT_W-1:0];
        o_totals.squared_error_total = sum_sse[pdstat_pkg::SSE_W] ? '1
                                     : sum_sse[pdstat_pkg::SSE_W-1:0];
        o_totals.sample_total        = sum_samp[pdstat_pkg::SAMP_W] ? '1
                                     : sum_samp[pdstat_pkg::SAMP_W-1:0];
    end

    // Accumulators update per pixel and clear after the frame's last pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_cnt <= '0;
            r_sse      <= '0;
            r_samp     <= '0;
        end else if (i_advance) begin
            if (i_last) begin
                r_diff_cnt <= '0;
                r_sse      <= '0;
                r_samp     <= '0;
            end else begin
                r_diff_cnt <= o_totals.differing_pixels;
                r_sse      <= o_totals.squared_error_total;
                r_samp     <= o_totals.sample_total;
            end
        end
    end

endmodule
